// ===== hw/rtl/dqd_pkg.sv =====
`default_nettype none

package dqd_pkg;

    // Transaction modes on the input channel
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CUD    = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    // Scheduling policy codes
    localparam logic [1:0] POL_STRICT = 2'd0;
    localparam logic [1:0] POL_RANK   = 2'd1;
    localparam logic [1:0] POL_BG     = 2'd2;
    localparam logic [1:0] POL_BANK   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_POLICY       = 1'b0;
    localparam logic CFG_CUD_DURATION = 1'b1;

    // Reset values of the configuration registers
    localparam logic [1:0]  POLICY_RESET       = POL_BANK;
    localparam logic [15:0] CUD_DURATION_RESET = 16'd64;

    // Compute instruction decode
    localparam int ROW_BITS         = 17;
    localparam int BANK_FIELD_SHIFT = 17;

    typedef struct packed {
        logic [47:0] addr;
        logic [1:0]  rank;
        logic [2:0]  bank_group;
        logic [1:0]  bank;
    } nreq_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] addr;
        logic [1:0]  rank;
        logic [2:0]  bank_group;
        logic [1:0]  bank;
        logic [31:0] op_word;
        logic        mem_ready;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic        dispatched;
        logic        from_cud;
        logic        blocked;
        logic        send_failed;
        logic [47:0] addr;
        logic [31:0] op_word;
        logic [1:0]  rank;
        logic [2:0]  bank_group;
        logic [1:0]  bank;
        logic [16:0] row;
    } result_t;

    function automatic logic [16:0] inst_row(input logic [31:0] w);
        logic [31:0] m;
        m = w & ((32'd1 << ROW_BITS) - 32'd1);
        return m[16:0];
    endfunction

    function automatic logic [2:0] inst_bg(input logic [31:0] w);
        logic [31:0] f;
        f = w >> BANK_FIELD_SHIFT;
        return f[4:2];
    endfunction

    function automatic logic [1:0] inst_bank(input logic [31:0] w);
        logic [31:0] f;
        f = w >> BANK_FIELD_SHIFT;
        return f[1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dual_queue_dram_command_dispatcher_top.sv =====
`default_nettype none

// Two-queue DRAM command dispatcher. Each input transaction is an enqueue of a
// normal request (mode 0), an enqueue of a compute instruction (mode 1) or a
// scheduling tick (mode 2), and it yields exactly one result transaction. The
// block takes one transaction per clock unless the result channel stalls; a
// transaction is registered on entry, decided against the registered queue
// heads and arbitration state once the result register is free or draining,
// and its result is held in an output register. A stalled result holds an entry
// in the input register. Queue heads are read through a registered memory port
// whose next-head address is computed in the same cycle as the pop or push.
// Configuration: index 0 is the policy (0 strict compute priority, 1..3
// alternation with rank, bank-group or bank conflict blocking), index 1 is the
// number of ticks a started compute instruction blocks conflicting requests.
module dual_queue_dram_command_dispatcher_top
    import dqd_pkg::*;
#(
    parameter int NORMAL_DEPTH = 16,
    parameter int CUD_DEPTH    = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // Input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [47:0] s_addr,
    input  wire logic [1:0]  s_rank,
    input  wire logic [2:0]  s_bank_group,
    input  wire logic [1:0]  s_bank,
    input  wire logic [31:0] s_op_word,
    input  wire logic        s_mem_ready,
    // Result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_accepted,
    output logic             m_dispatched,
    output logic             m_from_cud,
    output logic             m_blocked,
    output logic             m_send_failed,
    output logic [47:0]      m_out_addr,
    output logic [31:0]      m_out_op_word,
    output logic [1:0]       m_out_rank,
    output logic [2:0]       m_out_bank_group,
    output logic [1:0]       m_out_bank,
    output logic [16:0]      m_out_row
);

    logic [1:0]  policy_reg;
    logic [15:0] cud_duration_reg;

    logic        in_valid_reg;
    item_t       item_reg;
    logic        m_valid_reg;
    result_t     res_reg;
    result_t     res;

    logic        advance;
    logic        s_fire;
    logic        n_push, c_push, n_pop, c_pop;
    logic        n_full, n_empty, c_full, c_empty;
    nreq_t       n_head;
    nreq_t       n_wdata;
    logic [31:0] c_head;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg       <= POLICY_RESET;
            cud_duration_reg <= CUD_DURATION_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_POLICY:       policy_reg       <= cfg_wdata[1:0];
                CFG_CUD_DURATION: cud_duration_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: decide stage moves when the result register is free or draining
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.mode       <= s_mode;
            item_reg.addr       <= s_addr;
            item_reg.rank       <= s_rank;
            item_reg.bank_group <= s_bank_group;
            item_reg.bank       <= s_bank;
            item_reg.op_word    <= s_op_word;
            item_reg.mem_ready  <= s_mem_ready;
        end
    end

    assign n_wdata.addr       = item_reg.addr;
    assign n_wdata.rank       = item_reg.rank;
    assign n_wdata.bank_group = item_reg.bank_group;
    assign n_wdata.bank       = item_reg.bank;

    dqd_fifo #(
        .DEPTH (NORMAL_DEPTH),
        .WIDTH ($bits(nreq_t))
    ) u_normal_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (n_push),
        .push_data (n_wdata),
        .pop       (n_pop),
        .head_data (n_head),
        .full      (n_full),
        .empty     (n_empty)
    );

    dqd_fifo #(
        .DEPTH (CUD_DEPTH),
        .WIDTH (32)
    ) u_cud_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (c_push),
        .push_data (item_reg.op_word),
        .pop       (c_pop),
        .head_data (c_head),
        .full      (c_full),
        .empty     (c_empty)
    );

    dqd_sched u_sched (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .item         (item_reg),
        .policy       (policy_reg),
        .cud_duration (cud_duration_reg),
        .n_head       (n_head),
        .n_full       (n_full),
        .n_empty      (n_empty),
        .c_head       (c_head),
        .c_full       (c_full),
        .c_empty      (c_empty),
        .n_push       (n_push),
        .c_push       (c_push),
        .n_pop        (n_pop),
        .c_pop        (c_pop),
        .res          (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_accepted       = res_reg.accepted;
    assign m_dispatched     = res_reg.dispatched;
    assign m_from_cud       = res_reg.from_cud;
    assign m_blocked        = res_reg.blocked;
    assign m_send_failed    = res_reg.send_failed;
    assign m_out_addr       = res_reg.addr;
    assign m_out_op_word    = res_reg.op_word;
    assign m_out_rank       = res_reg.rank;
    assign m_out_bank_group = res_reg.bank_group;
    assign m_out_bank       = res_reg.bank;
    assign m_out_row        = res_reg.row;

    a_excl_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_dispatched && m_send_failed) && !(m_blocked && m_from_cud))
        else $error("conflicting status bits");
    a_blocked_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_blocked) |-> (!m_dispatched && !m_send_failed && m_out_addr == '0))
        else $error("blocked transaction carries a dispatch");
    a_addr_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_addr != '0) |-> (m_dispatched && !m_from_cud))
        else $error("address without normal dispatch");

endmodule

`default_nettype wire

// ===== hw/rtl/dqd_fifo.sv =====
`default_nettype none

module dqd_fifo #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] head_data_reg;
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;

    // Pointer and occupancy update
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop) begin
            head_next  = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
            count_next = count_reg - CW'(1);
        end
        if (push) begin
            tail_next  = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage with registered head read; a write into the next head slot is forwarded
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg] <= push_data;
        end
        if (push && (tail_reg == head_next)) begin
            head_data_reg <= push_data;
        end else begin
            head_data_reg <= mem[head_next];
        end
    end

    assign head_data = head_data_reg;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/dqd_sched.sv =====
`default_nettype none

module dqd_sched
    import dqd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        fire,
    input  wire item_t       item,
    input  wire logic [1:0]  policy,
    input  wire logic [15:0] cud_duration,
    input  wire nreq_t       n_head,
    input  wire logic        n_full,
    input  wire logic        n_empty,
    input  wire logic [31:0] c_head,
    input  wire logic        c_full,
    input  wire logic        c_empty,
    output logic             n_push,
    output logic             c_push,
    output logic             n_pop,
    output logic             c_pop,
    output result_t          res
);

    logic        last_was_cud_reg, last_was_cud_next;
    logic        cud_active_reg, cud_active_next;
    logic [31:0] active_inst_reg, active_inst_next;
    logic [31:0] active_start_reg, active_start_next;
    logic [31:0] tick_count_reg, tick_count_next;

    logic [31:0] tick_inc;
    logic [31:0] elapsed;
    logic        active_live;
    logic        r_hit, g_hit, b_hit, level_hit, conflict;
    logic        sel, is_cud, compute_turn;

    // Active-instruction window and conflict against the normal head
    always_comb begin
        tick_inc    = tick_count_reg + 32'd1;
        elapsed     = tick_inc - active_start_reg;
        active_live = cud_active_reg && (elapsed < {16'd0, cud_duration});
        r_hit       = (n_head.rank == 2'd0);
        g_hit       = (n_head.bank_group == inst_bg(active_inst_reg));
        b_hit       = (n_head.bank == inst_bank(active_inst_reg));
        unique case (policy)
            POL_STRICT: level_hit = 1'b0;
            POL_RANK:   level_hit = r_hit;
            POL_BG:     level_hit = r_hit && g_hit;
            POL_BANK:   level_hit = r_hit && g_hit && b_hit;
            default:    level_hit = 1'b0;
        endcase
        conflict = active_live && level_hit;
    end

    // Per-transaction decision
    always_comb begin
        res               = '0;
        n_push            = 1'b0;
        c_push            = 1'b0;
        n_pop             = 1'b0;
        c_pop             = 1'b0;
        sel               = 1'b0;
        is_cud            = 1'b0;
        compute_turn      = 1'b0;
        last_was_cud_next = last_was_cud_reg;
        cud_active_next   = cud_active_reg;
        active_inst_next  = active_inst_reg;
        active_start_next = active_start_reg;
        tick_count_next   = tick_count_reg;

        unique case (item.mode)
            MODE_NORMAL: begin
                if (!n_full) begin
                    n_push       = fire;
                    res.accepted = 1'b1;
                end
            end
            MODE_CUD: begin
                if (!c_full) begin
                    c_push       = fire;
                    res.accepted = 1'b1;
                end
            end
            MODE_TICK: begin
                tick_count_next = tick_inc;
                if (policy == POL_STRICT) begin
                    if (!c_empty) begin
                        sel    = 1'b1;
                        is_cud = 1'b1;
                    end else if (!n_empty) begin
                        sel = 1'b1;
                    end
                end else begin
                    cud_active_next = active_live;
                    if (!(c_empty && n_empty)) begin
                        compute_turn = !last_was_cud_reg;
                        if (compute_turn && c_empty) begin
                            compute_turn = 1'b0;
                        end
                        if (!compute_turn && n_empty) begin
                            compute_turn = 1'b1;
                        end
                        if (!compute_turn && conflict) begin
                            res.blocked = 1'b1;
                        end else begin
                            sel    = 1'b1;
                            is_cud = compute_turn;
                            last_was_cud_next = compute_turn;
                            // A new or different instruction restarts the window
                            if (compute_turn
                                && (!active_live || active_inst_reg != c_head)) begin
                                active_inst_next  = c_head;
                                cud_active_next   = 1'b1;
                                active_start_next = tick_inc;
                            end
                        end
                    end
                end

                if (sel) begin
                    res.from_cud    = is_cud;
                    res.dispatched  = item.mem_ready;
                    res.send_failed = !item.mem_ready;
                    if (is_cud) begin
                        res.bank_group = inst_bg(c_head);
                        res.bank       = inst_bank(c_head);
                        res.row        = inst_row(c_head);
                        if (item.mem_ready) begin
                            res.op_word = c_head;
                            c_pop       = fire;
                        end
                    end else begin
                        res.rank       = n_head.rank;
                        res.bank_group = n_head.bank_group;
                        res.bank       = n_head.bank;
                        if (item.mem_ready) begin
                            res.addr = n_head.addr;
                            n_pop    = fire;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Arbitration state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_was_cud_reg <= 1'b0;
            cud_active_reg   <= 1'b0;
            active_inst_reg  <= '0;
            active_start_reg <= '0;
            tick_count_reg   <= '0;
        end else if (fire) begin
            last_was_cud_reg <= last_was_cud_next;
            cud_active_reg   <= cud_active_next;
            active_inst_reg  <= active_inst_next;
            active_start_reg <= active_start_next;
            tick_count_reg   <= tick_count_next;
        end
    end

    a_one_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(n_pop && c_pop)) else $error("both queues popped");
    a_pop_is_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_pop || c_pop) |-> (fire && item.mode == MODE_TICK && item.mem_ready))
        else $error("pop outside a ready tick");

endmodule

`default_nettype wire
